FILE: hw/rtl/msca_pkg.sv
package msca_pkg;

    localparam int ID_W    = 16;
    localparam int DELAY_W = 16;
    localparam int REM_W   = 17;
    localparam int ENTRY_W = REM_W + ID_W;

    typedef enum logic [1:0] {
        KIND_SCHED  = 2'd0,
        KIND_CANCEL = 2'd1,
        KIND_TICK   = 2'd2,
        KIND_UNUSED = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_RSVD     = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [DELAY_W-1:0] delay;
        logic [ID_W-1:0]    alarm_id;
    } cmd_item_t;

    typedef struct packed {
        logic [ID_W-1:0] result_id;
        logic            fired;
        logic [1:0]      status;
        logic            last;
    } res_item_t;

endpackage

FILE: hw/rtl/msca_ram.sv
module msca_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/msca_oreg.sv
module msca_oreg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  msca_pkg::res_item_t  push_data,
    output logic                 push_free,
    output logic                 res_valid,
    input  logic                 res_stall,
    output msca_pkg::res_item_t  res
);

    import msca_pkg::*;

    logic      vld_reg;
    logic      vld_next;
    res_item_t data_reg;

    // free when empty or when the held item leaves this cycle
    assign push_free = !vld_reg || !res_stall;

    always_comb
    begin
        vld_next = vld_reg;
        if (push)
        begin
            vld_next = 1'b1;
        end
        else if (!res_stall)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg <= push_data;
        end
    end

    assign res_valid = vld_reg;
    assign res       = data_reg;

endmodule

FILE: hw/rtl/msca_ctrl.sv
module msca_ctrl #(
    parameter int SLOTS = 16,
    parameter int IDXW  = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_stall,
    input  msca_pkg::cmd_item_t           cmd,
    output logic                          push,
    output msca_pkg::res_item_t           push_data,
    input  logic                          push_free,
    output logic                          mem_we,
    output logic [IDXW-1:0]               mem_waddr,
    output logic [msca_pkg::ENTRY_W-1:0]  mem_wdata,
    output logic                          mem_re,
    output logic [IDXW-1:0]               mem_raddr,
    input  logic [msca_pkg::ENTRY_W-1:0]  mem_rdata
);

    import msca_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCHED = 4'b0010,
        S_SCAN  = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(SLOTS - 1);

    state_t               state_reg, state_next;
    logic [SLOTS-1:0]     live_reg, live_next;
    logic [ID_W-1:0]      id_cnt_reg, id_cnt_next;
    logic                 scan_act_reg, scan_act_next;
    logic                 eval_vld_reg, eval_vld_next;
    logic                 pend_vld_reg, pend_vld_next;
    logic                 found_reg, found_next;

    logic [1:0]           kind_reg, kind_next;
    logic [DELAY_W-1:0]   delay_reg, delay_next;
    logic [ID_W-1:0]      cid_reg, cid_next;
    logic [IDXW-1:0]      scan_idx_reg, scan_idx_next;
    logic [IDXW-1:0]      eval_idx_reg, eval_idx_next;
    logic [ID_W-1:0]      pend_id_reg, pend_id_next;
    res_item_t            fin_reg, fin_next;

    logic                 hold;
    logic [ID_W-1:0]      new_id;
    logic [REM_W-1:0]     rd_rem;
    logic [ID_W-1:0]      rd_ident;

    assign new_id   = id_cnt_reg + ID_W'(1);
    assign rd_rem   = mem_rdata[ENTRY_W-1:ID_W];
    assign rd_ident = mem_rdata[ID_W-1:0];

    always_comb
    begin
        state_next    = state_reg;
        live_next     = live_reg;
        id_cnt_next   = id_cnt_reg;
        scan_act_next = scan_act_reg;
        eval_vld_next = eval_vld_reg;
        pend_vld_next = pend_vld_reg;
        found_next    = found_reg;
        kind_next     = kind_reg;
        delay_next    = delay_reg;
        cid_next      = cid_reg;
        scan_idx_next = scan_idx_reg;
        eval_idx_next = eval_idx_reg;
        pend_id_next  = pend_id_reg;
        fin_next      = fin_reg;

        hold      = 1'b0;
        push      = 1'b0;
        push_data = '0;
        mem_we    = 1'b0;
        mem_waddr = eval_idx_reg;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = scan_idx_reg;
        cmd_stall = (state_reg != S_IDLE);

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    kind_next     = cmd.kind;
                    delay_next    = cmd.delay;
                    cid_next      = cmd.alarm_id;
                    scan_idx_next = '0;
                    case (cmd.kind)
                        KIND_SCHED:
                        begin
                            state_next = S_SCHED;
                        end
                        KIND_CANCEL, KIND_TICK:
                        begin
                            state_next    = S_SCAN;
                            scan_act_next = 1'b1;
                            eval_vld_next = 1'b0;
                            pend_vld_next = 1'b0;
                            found_next    = 1'b0;
                        end
                        default:
                        begin
                            // unused kind: dropped, no result
                        end
                    endcase
                end
            end

            S_SCHED:
            begin
                if (!live_reg[scan_idx_reg])
                begin
                    mem_we                  = 1'b1;
                    mem_waddr               = scan_idx_reg;
                    mem_wdata               = {REM_W'(delay_reg), new_id};
                    live_next[scan_idx_reg] = 1'b1;
                    id_cnt_next             = new_id;
                    fin_next = '{result_id: new_id, fired: 1'b0,
                                 status: ST_OK, last: 1'b1};
                    state_next = S_DONE;
                end
                else if (scan_idx_reg == LAST_IDX)
                begin
                    fin_next = '{result_id: '0, fired: 1'b0,
                                 status: ST_FULL, last: 1'b1};
                    state_next = S_DONE;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + IDXW'(1);
                end
            end

            S_SCAN:
            begin
                // evaluate stage: entry read in the previous step
                if (eval_vld_reg && live_reg[eval_idx_reg])
                begin
                    if (kind_reg == KIND_CANCEL)
                    begin
                        if (rd_ident == cid_reg)
                        begin
                            live_next[eval_idx_reg] = 1'b0;
                            found_next              = 1'b1;
                        end
                    end
                    else if (rd_rem <= REM_W'(1))
                    begin
                        // a fired id is held back until the next one shows
                        // whether it is the final item
                        if (pend_vld_reg && !push_free)
                        begin
                            hold = 1'b1;
                        end
                        else
                        begin
                            if (pend_vld_reg)
                            begin
                                push      = 1'b1;
                                push_data = '{result_id: pend_id_reg, fired: 1'b1,
                                              status: ST_OK, last: 1'b0};
                            end
                            pend_id_next            = rd_ident;
                            pend_vld_next           = 1'b1;
                            live_next[eval_idx_reg] = 1'b0;
                        end
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = eval_idx_reg;
                        mem_wdata = {rd_rem - REM_W'(1), rd_ident};
                    end
                end

                // read stage
                if (!hold)
                begin
                    mem_re        = scan_act_reg;
                    eval_vld_next = scan_act_reg;
                    eval_idx_next = scan_idx_reg;
                    if (scan_act_reg)
                    begin
                        if (scan_idx_reg == LAST_IDX)
                        begin
                            scan_act_next = 1'b0;
                        end
                        else
                        begin
                            scan_idx_next = scan_idx_reg + IDXW'(1);
                        end
                    end
                end

                if (!scan_act_reg && !eval_vld_reg)
                begin
                    if (kind_reg == KIND_CANCEL)
                    begin
                        fin_next = '{result_id: cid_reg, fired: 1'b0,
                                     status: found_reg ? ST_OK : ST_NOTFOUND,
                                     last: 1'b1};
                    end
                    else if (pend_vld_reg)
                    begin
                        fin_next = '{result_id: pend_id_reg, fired: 1'b1,
                                     status: ST_OK, last: 1'b1};
                    end
                    else
                    begin
                        fin_next = '{result_id: '0, fired: 1'b0,
                                     status: ST_OK, last: 1'b1};
                    end
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (push_free)
                begin
                    push       = 1'b1;
                    push_data  = fin_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            live_reg     <= '0;
            id_cnt_reg   <= '0;
            scan_act_reg <= 1'b0;
            eval_vld_reg <= 1'b0;
            pend_vld_reg <= 1'b0;
            found_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            live_reg     <= live_next;
            id_cnt_reg   <= id_cnt_next;
            scan_act_reg <= scan_act_next;
            eval_vld_reg <= eval_vld_next;
            pend_vld_reg <= pend_vld_next;
            found_reg    <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        delay_reg    <= delay_next;
        cid_reg      <= cid_next;
        scan_idx_reg <= scan_idx_next;
        eval_idx_reg <= eval_idx_next;
        pend_id_reg  <= pend_id_next;
        fin_reg      <= fin_next;
    end

endmodule

FILE: hw/rtl/multi_slot_countdown_alarms.sv
// Table of SLOTS countdown alarms.
// cmd channel (cmd_valid / cmd_stall / cmd): one item per command: schedule,
// cancel or one-second tick. An item is taken when cmd_valid is high and
// cmd_stall low; kind 3 is taken and dropped without a result.
// res channel (res_valid / res_stall / res): schedule and cancel give one
// result item each; a tick gives one item per fired alarm in slot order, or a
// single empty item, with last set on the final one.
// Timing: a schedule searches the live bits one slot a cycle. Cancel and tick
// sweep the slot memory (one read port, one write port, registered read), one
// entry a cycle, except that a tick pauses while the output register cannot
// take a fired id. One item is in flight at a time: the next item is taken
// only once the current one has handed its final result to the output
// register; kind 3 leaves the block idle.
// A finished result sits in an output register, so the next item is taken
// while it waits. When res_stall holds off a tick's results the sweep pauses
// and resumes where it stopped; nothing is lost.
// Reset (rst_n, asynchronous, active low) frees every slot and zeroes the id
// counter; it takes effect at once, with no clearing pass.
module multi_slot_countdown_alarms #(
    parameter int SLOTS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  msca_pkg::cmd_item_t  cmd,
    output logic                 res_valid,
    input  logic                 res_stall,
    output msca_pkg::res_item_t  res
);

    import msca_pkg::*;

    localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic                push;
    res_item_t           push_data;
    logic                push_free;
    logic                mem_we;
    logic [IDXW-1:0]     mem_waddr;
    logic [ENTRY_W-1:0]  mem_wdata;
    logic                mem_re;
    logic [IDXW-1:0]     mem_raddr;
    logic [ENTRY_W-1:0]  mem_rdata;

    msca_ctrl #(
        .SLOTS (SLOTS),
        .IDXW  (IDXW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .push      (push),
        .push_data (push_data),
        .push_free (push_free),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // entry: remaining count above, id below
    msca_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS),
        .AW    (IDXW)
    ) u_slot_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    msca_oreg u_oreg (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .push_free (push_free),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule

FILE: bench/tb_multi_slot_countdown_alarms.sv
`timescale 1ns / 100ps

import msca_pkg::*;

localparam int SLOT_COUNT = 16;

// Shadow copy of the alarm table; works out the result items for each command
class alarm_table_tracker;
    bit               live [SLOT_COUNT];
    logic [REM_W-1:0] remain [SLOT_COUNT];
    logic [ID_W-1:0]  ident [SLOT_COUNT];
    logic [ID_W-1:0]  id_ctr;
    res_item_t        awaited_results [$];
    int               mismatches;
    int               checked;
    int               fired_count;
    int               full_count;
    int               notfound_count;

    function new();
        id_ctr = '0;
        mismatches = 0;
        checked = 0;
        fired_count = 0;
        full_count = 0;
        notfound_count = 0;
        foreach (live[i])
            live[i] = 1'b0;
    endfunction

    function void push_result(logic [ID_W-1:0] id, logic f, status_t st, logic l);
        res_item_t r;
        r.result_id = id;
        r.fired = f;
        r.status = st;
        r.last = l;
        awaited_results.push_back(r);
    endfunction

    function logic [ID_W-1:0] any_live_id(output bit found);
        logic [ID_W-1:0] ids [$];
        foreach (live[i])
            if (live[i])
                ids.push_back(ident[i]);
        found = ids.size() != 0;
        return found ? ids[$urandom_range(0, ids.size() - 1)] : '0;
    endfunction

    function void note_command(cmd_item_t c);
        int i;
        int slot;
        int n;
        bit hit;
        slot = -1;
        n = 0;
        hit = 1'b0;
        case (c.kind)
            KIND_SCHED:
            begin
                for (i = SLOT_COUNT - 1; i >= 0; i--)
                    if (!live[i])
                        slot = i;
                if (slot < 0)
                begin
                    push_result('0, 1'b0, ST_FULL, 1'b1);
                    full_count++;
                end
                else
                begin
                    id_ctr = id_ctr + 1'b1;
                    live[slot] = 1'b1;
                    remain[slot] = {1'b0, c.delay};
                    ident[slot] = id_ctr;
                    push_result(id_ctr, 1'b0, ST_OK, 1'b1);
                end
            end
            KIND_CANCEL:
            begin
                // every matching slot goes, duplicates after a wrap included
                for (i = 0; i < SLOT_COUNT; i++)
                    if (live[i] && ident[i] == c.alarm_id)
                    begin
                        live[i] = 1'b0;
                        hit = 1'b1;
                    end
                push_result(c.alarm_id, 1'b0, hit ? ST_OK : ST_NOTFOUND, 1'b1);
                if (!hit)
                    notfound_count++;
            end
            KIND_TICK:
            begin
                for (i = 0; i < SLOT_COUNT; i++)
                    if (live[i])
                    begin
                        if (remain[i] <= 1)
                        begin
                            live[i] = 1'b0;
                            push_result(ident[i], 1'b1, ST_OK, 1'b0);
                            n++;
                        end
                        else
                            remain[i] = remain[i] - 1'b1;
                    end
                if (n == 0)
                    push_result('0, 1'b0, ST_OK, 1'b1);
                else
                    awaited_results[awaited_results.size() - 1].last = 1'b1;
                fired_count += n;
            end
            default:
            begin
                // unused kind: dropped, no result
            end
        endcase
    endfunction

    function void flag(string what, res_item_t want, res_item_t got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%s at result %0d: expected id %h fired %b status %0d last %b",
                     what, checked, want.result_id, want.fired, want.status, want.last);
            $display("    got id %h fired %b status %0d last %b",
                     got.result_id, got.fired, got.status, got.last);
        end
    endfunction

    function void check_result(res_item_t got);
        res_item_t want;
        checked++;
        if (awaited_results.size() == 0)
        begin
            want = '0;
            flag("unexpected item", want, got);
        end
        else
        begin
            want = awaited_results.pop_front();
            if (got.result_id !== want.result_id || got.fired !== want.fired ||
                got.status !== want.status || got.last !== want.last)
                flag("mismatch", want, got);
        end
    endfunction
endclass

module tb_multi_slot_countdown_alarms;

    localparam int CYCLE_LIMIT = 200_000;
    localparam int LONG_HOLD = 300;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      cmd_valid;
    logic      cmd_stall;
    cmd_item_t cmd;
    logic      res_valid;
    logic      res_stall;
    res_item_t res;

    logic hold_off;
    bit   send_quiet = 1'b0;
    bit   in_random = 1'b0;
    int   results_seen = 0;
    int   items_sent = 0;
    int   pressure_at = 0;
    int   cycle_count = 0;

    alarm_table_tracker alarms;

    multi_slot_countdown_alarms #(
        .SLOTS(SLOT_COUNT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd(cmd),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res(res)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timed out with %0d result items outstanding",
                     alarms.awaited_results.size());
            $display("status: fail");
            $finish;
        end
    end

    // valid stays high across back-to-back items; only lowered for a gap
    task automatic send(kind_t k, logic [DELAY_W-1:0] d, logic [ID_W-1:0] id);
        int gap;
        gap = send_quiet ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= '{k, d, id};
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        alarms.note_command(cmd);
        items_sent++;
    endtask

    // result side
    initial
    begin
        int hold;
        hold = 0;
        res_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (res_valid && !res_stall)
            begin
                alarms.check_result(res);
                results_seen++;
                if ((results_seen / 40) % 4 == 3)
                    hold = 0;
                else
                    hold = $urandom_range(0, 3);
            end
            else if (hold > 0)
                hold--;
            res_stall <= hold_off || hold > 0;
        end
    end

    // one long hold-off on results so the block backs up into cmd_stall
    initial
    begin
        hold_off <= 1'b0;
        wait (in_random);
        wait (results_seen >= pressure_at);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        int              n;
        int              pick;
        bit              found;
        logic [ID_W-1:0] id;
        logic [DELAY_W-1:0] d;

        alarms = new();
        rst_n <= 1'b0;
        cmd_valid <= 1'b0;
        cmd <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        send(KIND_TICK, 16'hFFFF, 16'h0000);          // nothing live: empty item
        send(KIND_CANCEL, 16'h0000, 16'hFFFF);        // unknown id
        send(KIND_UNUSED, 16'hFFFF, 16'hFFFF);        // dropped
        send(KIND_SCHED, 16'd0, 16'hFFFF);            // zero delay fires next tick
        send(KIND_SCHED, 16'd1, 16'h0000);
        send(KIND_SCHED, 16'd2, 16'h0000);
        send(KIND_SCHED, 16'hFFFF, 16'h0000);
        send(KIND_TICK, 16'h0000, 16'h0000);          // two fire at once
        send(KIND_CANCEL, 16'h0000, 16'd3);
        send(KIND_CANCEL, 16'h0000, 16'd3);           // already gone
        send(KIND_TICK, 16'h0000, 16'h0000);
        repeat (15)
            send(KIND_SCHED, 16'd0, 16'($urandom));
        send(KIND_SCHED, 16'd7, 16'($urandom));       // table full
        send(KIND_TICK, 16'($urandom), 16'($urandom)); // fifteen fire

        // random part, mostly live ids and short delays so ticks keep firing
        pressure_at = results_seen + 60;
        in_random = 1'b1;
        n = 0;
        while (n < 260)
        begin
            if (n % 32 == 0)
                send_quiet = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 5)
                send(KIND_UNUSED, 16'($urandom), 16'($urandom));
            else
            begin
                n++;
                if (pick < 45)
                begin
                    pick = $urandom_range(0, 9);
                    if (pick < 6)
                        d = 16'($urandom_range(0, 6));
                    else if (pick < 8)
                        d = 16'($urandom_range(0, 40));
                    else
                        d = 16'($urandom);
                    send(KIND_SCHED, d, 16'($urandom));
                end
                else if (pick < 70)
                begin
                    id = alarms.any_live_id(found);
                    if (!found || $urandom_range(0, 3) == 0)
                        id = 16'($urandom);
                    send(KIND_CANCEL, 16'($urandom), id);
                end
                else
                    send(KIND_TICK, 16'($urandom), 16'($urandom));
            end
        end

        send_quiet = 1'b0;
        send(KIND_SCHED, 16'd0, 16'($urandom));
        send(KIND_TICK, 16'($urandom), 16'($urandom));

        cmd_valid <= 1'b0;
        while (alarms.awaited_results.size() != 0)
            @(posedge clk);
        repeat (3 * SLOT_COUNT) @(posedge clk);

        $display("%0d items, %0d results checked: %0d fired, %0d refused as full,",
                 items_sent, alarms.checked, alarms.fired_count, alarms.full_count);
        $display("%0d cancels of unknown ids, a %0d-cycle result hold-off, %0d mismatches",
                 alarms.notfound_count, LONG_HOLD, alarms.mismatches);
        if (alarms.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
